[rtl/cfr_pkg.sv]
// Shared types, constants and elaboration-time table builders for the frame rotation.
package cfr_pkg;

    localparam int ANGLE_BITS = 32;
    localparam int COEF_BITS  = 32;
    localparam int TURN_BITS  = 60;
    localparam int VEC_FRAC   = 58;
    localparam int COEF_FRAC  = COEF_BITS - 2;
    localparam int ITERS      = 58;
    localparam int IDX_W      = $clog2(ITERS);
    localparam int FIELD_SH   = TURN_BITS - ANGLE_BITS;

    typedef logic signed [63:0] s64_t;
    typedef logic [63:0] atan_tab_t [ITERS];
    typedef s64_t coef_tab_t [9];

    typedef struct packed {
        logic [ANGLE_BITS-1:0]        ra_angle;
        logic signed [ANGLE_BITS-1:0] dec_angle;
    } cfr_in_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]        lon_angle;
        logic signed [ANGLE_BITS-1:0] lat_angle;
    } cfr_out_t;

    // rotation-mode CORDIC slice
    typedef struct packed {
        logic valid;
        logic neg;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] t;
    } cfr_rot_t;

    // vectoring-mode CORDIC slice; side rides along untouched
    typedef struct packed {
        logic valid;
        logic zero;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] side;
    } cfr_vec_t;

    localparam s64_t QUARTER = s64_t'(64'd1 << (TURN_BITS - 2));
    localparam s64_t HALF    = s64_t'(64'd1 << (TURN_BITS - 1));

    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int k = 63; k >= 0; k--)
        begin
            r = {r[63:0], n[k]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den,
                                             input int bits);
        logic [63:0] r;
        logic [63:0] q;
        r = num;
        q = '0;
        for (int k = 0; k < bits; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] frac_round(input logic [63:0] num, input logic [63:0] den,
                                               input int bits);
        return (frac_div(num, den, bits + 1) + 64'd1) >> 1;
    endfunction

    function automatic logic [63:0] atan_series(input logic [63:0] p, input logic [63:0] m2,
                                                input int sh2);
        logic [63:0] sum;
        logic [63:0] t;
        logic [63:0] pp;
        logic [63:0] k;
        sum = '0;
        k   = '0;
        pp  = p;
        while (pp != 64'd0)
        begin
            t = udiv(pp, (k << 1) + 64'd1);
            if (k[0])
                sum = sum - t;
            else
                sum = sum + t;
            if (m2 != 64'd0)
                pp = udiv(pp, m2);
            else if (sh2 < 64)
                pp = pp >> sh2;
            else
                pp = '0;
            k = k + 64'd1;
        end
        return sum;
    endfunction

    function automatic atan_tab_t build_atan();
        atan_tab_t   tab;
        logic [63:0] pi62;
        logic [63:0] inv2pi;
        logic [127:0] prod;
        pi62 = 64'd16 * atan_series(udiv(64'd1 << 62, 64'd5), 64'd25, 0)
             - 64'd4 * atan_series(udiv(64'd1 << 62, 64'd239), 64'd57121, 0);
        inv2pi = frac_div(64'd1 << 60, pi62 >> 1, 64);
        tab[0] = 64'd1 << (TURN_BITS - 3);
        for (int i = 1; i < ITERS; i++)
        begin
            prod = {64'd0, atan_series((64'd1 << 62) >> i, 64'd0, 2 * i)} * {64'd0, inv2pi};
            prod = (prod + (128'd1 << (62 + 64 - TURN_BITS - 1))) >> (62 + 64 - TURN_BITS);
            tab[i] = prod[63:0];
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan();

    function automatic logic [63:0] cordic_gain();
        s64_t x;
        s64_t y;
        s64_t dx;
        s64_t dy;
        x = s64_t'(64'd1 << 57);
        y = '0;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
            end
            else
            begin
                x = x - dx;
                y = y + dy;
            end
        end
        return x;
    endfunction

    localparam s64_t INV_GAIN = s64_t'(frac_round(64'd1 << 57, cordic_gain(), VEC_FRAC));

    // cos and sin of the obliquity, rounded to the coefficient format
    function automatic logic [127:0] obliquity_cs();
        s64_t x;
        s64_t y;
        s64_t t;
        s64_t dx;
        s64_t dy;
        int   sh;
        sh = VEC_FRAC - COEF_FRAC;
        x = INV_GAIN;
        y = '0;
        t = s64_t'(frac_round(64'd23439291111, 64'd360000000000, TURN_BITS));
        for (int i = 0; i < ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (t >= 0)
            begin
                x = x - dx;
                y = y + dy;
                t = t - s64_t'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                t = t + s64_t'(ATAN_TAB[i]);
            end
        end
        x = (x + s64_t'(64'd1 << (sh - 1))) >>> sh;
        y = (y + s64_t'(64'd1 << (sh - 1))) >>> sh;
        return {x, y};
    endfunction

    localparam s64_t GAL_NUM [9] = '{
        -64'sd5487548209352,  -64'sd87343711004849, -64'sd48383498866363,
        64'sd49410957812535,  -64'sd44482953746567, 64'sd74698220019146,
        -64'sd86766606840984, -64'sd19807649378008, 64'sd45598387728295
    };

    function automatic coef_tab_t build_gal();
        coef_tab_t   tab;
        logic [63:0] q;
        for (int i = 0; i < 9; i++)
        begin
            q = frac_round(GAL_NUM[i] < 0 ? 64'(-GAL_NUM[i]) : 64'(GAL_NUM[i]),
                           64'd100000000000000, COEF_FRAC);
            tab[i] = GAL_NUM[i] < 0 ? -s64_t'(q) : s64_t'(q);
        end
        return tab;
    endfunction

    function automatic coef_tab_t build_ecl();
        coef_tab_t    tab;
        logic [127:0] cs;
        cs = obliquity_cs();
        tab[0] = s64_t'(64'd1 << COEF_FRAC);
        tab[1] = '0;
        tab[2] = '0;
        tab[3] = '0;
        tab[4] = s64_t'(cs[127:64]);
        tab[5] = s64_t'(cs[63:0]);
        tab[6] = '0;
        tab[7] = -s64_t'(cs[63:0]);
        tab[8] = s64_t'(cs[127:64]);
        return tab;
    endfunction

    localparam coef_tab_t COEF_GAL = build_gal();
    localparam coef_tab_t COEF_ECL = build_ecl();

    // pre-rotate by a half turn for x < 0, flag the zero vector
    function automatic cfr_vec_t vec_prep(input logic v, input s64_t x, input s64_t y,
                                          input s64_t side);
        cfr_vec_t r;
        r.valid = v;
        r.zero  = (x == 0) && (y == 0);
        r.side  = side;
        if (x < 0)
        begin
            r.x = -x;
            r.y = -y;
            r.z = HALF;
        end
        else
        begin
            r.x = x;
            r.y = y;
            r.z = '0;
        end
        return r;
    endfunction

endpackage

[rtl/cfr_rot_cell.sv]
// One rotation-mode CORDIC slice with its output register.
module cfr_rot_cell
    import cfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  cfr_rot_t         cur,
    output cfr_rot_t         nxt
);

    cfr_rot_t stage_reg;
    cfr_rot_t stage_next;
    s64_t     dx;
    s64_t     dy;
    s64_t     ang;

    always_comb
    begin
        dx  = s64_t'(cur.y) >>> idx;
        dy  = s64_t'(cur.x) >>> idx;
        ang = s64_t'(ATAN_TAB[idx]);
        stage_next = cur;
        if (!cur.t[63])
        begin
            stage_next.x = cur.x - dx;
            stage_next.y = cur.y + dy;
            stage_next.t = cur.t - ang;
        end
        else
        begin
            stage_next.x = cur.x + dx;
            stage_next.y = cur.y - dy;
            stage_next.t = cur.t + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg.valid <= 1'b0;
        else
            stage_reg <= stage_next;
    end

    assign nxt = stage_reg;

endmodule

[rtl/cfr_vec_cell.sv]
// One vectoring-mode CORDIC slice with its output register.
module cfr_vec_cell
    import cfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  cfr_vec_t         cur,
    output cfr_vec_t         nxt
);

    cfr_vec_t stage_reg;
    cfr_vec_t stage_next;
    s64_t     dx;
    s64_t     dy;
    s64_t     ang;

    always_comb
    begin
        dx  = s64_t'(cur.y) >>> idx;
        dy  = s64_t'(cur.x) >>> idx;
        ang = s64_t'(ATAN_TAB[idx]);
        stage_next = cur;
        if (!cur.y[63])
        begin
            stage_next.x = cur.x + dx;
            stage_next.y = cur.y - dy;
            stage_next.z = cur.z + ang;
        end
        else
        begin
            stage_next.x = cur.x - dx;
            stage_next.y = cur.y + dy;
            stage_next.z = cur.z - ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg.valid <= 1'b0;
        else
            stage_reg <= stage_next;
    end

    assign nxt = stage_reg;

endmodule

[rtl/cfr_mul.sv]
// Two-stage signed multiply, rounded half away from zero, split into 32-bit partials.
module cfr_mul
    import cfr_pkg::*;
(
    input  logic       clk,
    input  s64_t       a,
    input  s64_t       b,
    input  logic [6:0] shift,
    output s64_t       p
);

    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  pp00_reg;
    logic [63:0]  pp01_reg;
    logic [63:0]  pp10_reg;
    logic [63:0]  pp11_reg;
    logic         neg_reg;
    logic [127:0] full;
    logic [127:0] rnd;
    logic [63:0]  mag;
    s64_t         p_reg;

    assign ua = a[63] ? 64'(-a) : 64'(a);
    assign ub = b[63] ? 64'(-b) : 64'(b);

    always_ff @(posedge clk)
    begin
        pp00_reg <= ua[31:0]  * ub[31:0];
        pp01_reg <= ua[31:0]  * ub[63:32];
        pp10_reg <= ua[63:32] * ub[31:0];
        pp11_reg <= ua[63:32] * ub[63:32];
        neg_reg  <= a[63] ^ b[63];
    end

    always_comb
    begin
        full = {64'd0, pp00_reg} + ({64'd0, pp01_reg} << 32) + ({64'd0, pp10_reg} << 32)
             + ({64'd0, pp11_reg} << 64);
        rnd  = (full + (128'd1 << (shift - 7'd1))) >> shift;
        mag  = {1'b0, rnd[62:0]};
    end

    always_ff @(posedge clk)
    begin
        p_reg <= neg_reg ? -s64_t'(mag) : s64_t'(mag);
    end

    assign p = p_reg;

endmodule

[rtl/celestial_frame_rotation.sv]
// Top level: J2000 equatorial to galactic or ecliptic coordinates, fully pipelined.
//
//   channel   | ports                        | direction | timing
//   ----------+------------------------------+-----------+-------------------------------
//   command   | start, busy, operand         | in        | word taken when start & !busy
//   result    | done, result                 | out       | word valid for the done cycle
//   config    | cfg_we, cfg_wdata            | in        | frame select, taken on cfg_we
//
// One word enters every cycle; busy stays low. Each word passes in turn through three
// chains of 58 CORDIC slices (sine/cosine, longitude, latitude) and the multiplier and
// matrix stages between them. Reset clears the valid marks along the pipe and the
// frame register (galactic). The receiver cannot stall, so done is a one-cycle strobe.
module celestial_frame_rotation
    import cfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  cfr_in_t  operand,
    output logic     done,
    output cfr_out_t result,
    input  logic     cfg_we,
    input  logic     cfg_wdata
);

    logic frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_reg <= 1'b0;
        else if (cfg_we)
            frame_reg <= cfg_wdata;
    end

    assign busy = 1'b0;

    // map to internal turns and fold into a quarter turn either side of zero
    function automatic cfr_rot_t rot_prep(input logic v, input logic [ANGLE_BITS-1:0] a);
        cfr_rot_t r;
        logic signed [TURN_BITS-1:0] tv;
        s64_t t;
        tv = {a, {FIELD_SH{1'b0}}};
        t  = s64_t'(tv);
        r.valid = v;
        r.neg   = 1'b0;
        r.x     = INV_GAIN;
        r.y     = '0;
        if (t > QUARTER)
        begin
            t = t - HALF;
            r.neg = 1'b1;
        end
        else if (t < -QUARTER)
        begin
            t = t + HALF;
            r.neg = 1'b1;
        end
        r.t = t;
        return r;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] to_field(input s64_t ang);
        logic [63:0] u;
        u = 64'(ang) + (64'd1 << (FIELD_SH - 1));
        return u[FIELD_SH + ANGLE_BITS - 1:FIELD_SH];
    endfunction

    // sine/cosine lanes for right ascension and declination
    cfr_rot_t ra_pipe  [ITERS+1];
    cfr_rot_t dec_pipe [ITERS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ra_pipe[0].valid  <= 1'b0;
            dec_pipe[0].valid <= 1'b0;
        end
        else
        begin
            ra_pipe[0]  <= rot_prep(start && !busy, operand.ra_angle);
            dec_pipe[0] <= rot_prep(1'b0, operand.dec_angle);
        end
    end

    for (genvar i = 0; i < ITERS; i++)
    begin : g_rot
        cfr_rot_cell u_ra (
            .clk(clk), .rst_n(rst_n), .idx(IDX_W'(i)), .cur(ra_pipe[i]), .nxt(ra_pipe[i+1])
        );
        cfr_rot_cell u_dec (
            .clk(clk), .rst_n(rst_n), .idx(IDX_W'(i)), .cur(dec_pipe[i]), .nxt(dec_pipe[i+1])
        );
    end

    s64_t cr;
    s64_t sr;
    s64_t cd;
    s64_t sd;

    always_comb
    begin
        cr = ra_pipe[ITERS].neg  ? -s64_t'(ra_pipe[ITERS].x)  : s64_t'(ra_pipe[ITERS].x);
        sr = ra_pipe[ITERS].neg  ? -s64_t'(ra_pipe[ITERS].y)  : s64_t'(ra_pipe[ITERS].y);
        cd = dec_pipe[ITERS].neg ? -s64_t'(dec_pipe[ITERS].x) : s64_t'(dec_pipe[ITERS].x);
        sd = dec_pipe[ITERS].neg ? -s64_t'(dec_pipe[ITERS].y) : s64_t'(dec_pipe[ITERS].y);
    end

    // unit vector: cos(dec)cos(ra), cos(dec)sin(ra), sin(dec)
    s64_t vec [3];
    logic [1:0] uv_valid_reg;
    s64_t sd1_reg;
    s64_t sd2_reg;

    cfr_mul u_mul_x (.clk(clk), .a(cd), .b(cr), .shift(7'(VEC_FRAC)), .p(vec[0]));
    cfr_mul u_mul_y (.clk(clk), .a(cd), .b(sr), .shift(7'(VEC_FRAC)), .p(vec[1]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            uv_valid_reg <= '0;
        else
            uv_valid_reg <= {uv_valid_reg[0], ra_pipe[ITERS].valid};
    end

    always_ff @(posedge clk)
    begin
        sd1_reg <= sd;
        sd2_reg <= sd1_reg;
    end

    assign vec[2] = sd2_reg;

    // matrix rotation: nine products, then a row sum stage
    s64_t prod [9];
    logic [1:0] mx_valid_reg;

    for (genvar k = 0; k < 9; k++)
    begin : g_mat
        s64_t coef;
        assign coef = frame_reg ? COEF_ECL[k] : COEF_GAL[k];
        cfr_mul u_mul (.clk(clk), .a(coef), .b(vec[k % 3]), .shift(7'(COEF_FRAC)), .p(prod[k]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mx_valid_reg <= '0;
        else
            mx_valid_reg <= {mx_valid_reg[0], uv_valid_reg[1]};
    end

    s64_t w_reg [3];
    logic w_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_valid_reg <= 1'b0;
        else
            w_valid_reg <= mx_valid_reg[1];
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            w_reg[r] <= prod[3*r] + prod[3*r+1] + prod[3*r+2];
        end
    end

    // longitude: vectoring on (w0, w1), carry w2 along
    cfr_vec_t lon_pipe [ITERS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lon_pipe[0].valid <= 1'b0;
        else
            lon_pipe[0] <= vec_prep(w_valid_reg, w_reg[0], w_reg[1], w_reg[2]);
    end

    for (genvar i = 0; i < ITERS; i++)
    begin : g_lon
        cfr_vec_cell u_cell (
            .clk(clk), .rst_n(rst_n), .idx(IDX_W'(i)), .cur(lon_pipe[i]), .nxt(lon_pipe[i+1])
        );
    end

    s64_t lon_ang;
    s64_t lon_mag;
    s64_t rad;

    assign lon_ang = lon_pipe[ITERS].zero ? '0 : s64_t'(lon_pipe[ITERS].z);
    assign lon_mag = lon_pipe[ITERS].zero ? '0 : s64_t'(lon_pipe[ITERS].x);

    // drop the CORDIC gain from the equatorial radius
    cfr_mul u_mul_gain (.clk(clk), .a(lon_mag), .b(INV_GAIN), .shift(7'(VEC_FRAC)), .p(rad));

    logic [1:0] g_valid_reg;
    s64_t lon1_reg;
    s64_t lon2_reg;
    s64_t z1_reg;
    s64_t z2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= '0;
        else
            g_valid_reg <= {g_valid_reg[0], lon_pipe[ITERS].valid};
    end

    always_ff @(posedge clk)
    begin
        lon1_reg <= lon_ang;
        lon2_reg <= lon1_reg;
        z1_reg   <= lon_pipe[ITERS].side;
        z2_reg   <= z1_reg;
    end

    // latitude: vectoring on (radius, w2), carry longitude along
    cfr_vec_t lat_pipe [ITERS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lat_pipe[0].valid <= 1'b0;
        else
            lat_pipe[0] <= vec_prep(g_valid_reg[1], rad, z2_reg, lon2_reg);
    end

    for (genvar i = 0; i < ITERS; i++)
    begin : g_lat
        cfr_vec_cell u_cell (
            .clk(clk), .rst_n(rst_n), .idx(IDX_W'(i)), .cur(lat_pipe[i]), .nxt(lat_pipe[i+1])
        );
    end

    // hold the result word for its single strobe cycle
    logic     done_reg;
    cfr_out_t result_reg;
    s64_t     lat_ang;

    assign lat_ang = lat_pipe[ITERS].zero ? '0 : s64_t'(lat_pipe[ITERS].z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= lat_pipe[ITERS].valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg.lon_angle <= to_field(s64_t'(lat_pipe[ITERS].side));
        result_reg.lat_angle <= to_field(lat_ang);
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
